FILE: design/iirc_pkg.sv
// ----------------------------------------------------------------------------
// iirc_pkg
// Shared types and constants of the I/O interrupt redirection controller.
// ----------------------------------------------------------------------------
package iirc_pkg;

	localparam int NUM_PINS = 24;
	localparam int PIN_W    = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

	localparam logic [7:0] OFF_SELECT     = 8'h00;
	localparam logic [7:0] OFF_WINDOW     = 8'h10;
	localparam logic [7:0] OFF_EOI        = 8'h40;
	localparam logic [7:0] SEL_ID         = 8'h00;
	localparam logic [7:0] SEL_VERSION    = 8'h01;
	localparam logic [7:0] SEL_ENTRY_BASE = 8'h10;
	localparam logic [7:0] SEL_ENTRY_LAST = 8'(16 + 2 * NUM_PINS - 1);
	localparam logic [31:0] VERSION_WORD  = 32'h21 | (32'(NUM_PINS - 1) << 16);

	localparam int B_DSTATUS = 12;
	localparam int B_RIRR    = 14;
	localparam int B_LEVEL   = 15;
	localparam int B_MASK    = 16;
	localparam logic [31:0] RO_BITS = (32'd1 << B_DSTATUS) | (32'd1 << B_RIRR);

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_PIN   = 2'd2
	} cmd_e_t;

	typedef enum logic [1:0] {
		OP_WR_LO,
		OP_WR_HI,
		OP_EOI,
		OP_PIN
	} op_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic        en;
		op_e_t       kind;
		logic [31:0] wdata;
		logic        level;
		logic        accepts;
	} cell_op_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  vector;
		logic [15:0] dest;
		logic [2:0]  mode;
	} dlv_t;

endpackage

FILE: design/io_interrupt_redirection_controller_core.sv
// ----------------------------------------------------------------------------
// io_interrupt_redirection_controller_core
// Bus register interface, pin events and interrupt delivery over a pin chain.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                        tuser         tlast
// s_*      in   offset, write_data, pin_index, level, accepts cmd          -
// m_*      out  read_data, irq_vector, irq_destination, mode  result_kind  last
//
// Reads, select writes and ignored requests go from IDLE to FLUSH; a window write,
// pin change or EOI goes IDLE, SCAN, FLUSH. An EOI walks the token over all
// NUM_PINS cells, one per cycle while the output is not stalled. Reset clears all
// control state and sets every entry's mask bit. A stalled output register
// halts the walk while a second result is waiting.
// ----------------------------------------------------------------------------
module io_interrupt_redirection_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // offset, write_data, pin_index, pin_level_in, sink_accepts
	input  logic [1:0]  s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // read_data, irq_vector, irq_destination, irq_delivery_mode
	output logic [0:0]  m_tuser,  // result_kind
	output logic        m_tlast
);
	import iirc_pkg::*;

	state_t      state_q, state_n;
	logic [31:0] sel_q;
	cell_op_t    op_q;
	logic        hold_v_q, hold_kind_q;
	logic [58:0] hold_q;
	logic        out_v_q, out_kind_q, out_last_q;
	logic [58:0] out_q;

	logic [7:0]       offset;
	logic [31:0]      wdata;
	logic [5:0]       pin_index;
	logic             accept, out_free, en, scan_done;
	logic             start, go_scan, go_read;
	op_e_t            start_kind;
	logic [PIN_W-1:0] tgt_pin;
	logic [7:0]       sel8, wsub;
	logic             sel_entry;
	logic [PIN_W-1:0] win_pin;
	logic [31:0]      rd;
	logic [31:0]      ent_lo [NUM_PINS];
	logic [31:0]      ent_hi [NUM_PINS];
	logic             tok_last;
	dlv_t             dlv;
	cell_op_t         cop;

	assign offset    = s_tdata[7:0];
	assign wdata     = s_tdata[39:8];
	assign pin_index = s_tdata[45:40];
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_v_q || m_tready;
	assign sel8      = sel_q[7:0];
	assign wsub      = sel8 - SEL_ENTRY_BASE;
	assign win_pin   = wsub[PIN_W:1];
	assign sel_entry = (sel8 >= SEL_ENTRY_BASE) && (sel8 <= SEL_ENTRY_LAST);

	always_comb begin
		rd = '0;
		if (offset == OFF_SELECT) begin
			rd = sel_q;
		end else if (offset == OFF_WINDOW) begin
			if (sel8 == SEL_ID) begin
				rd = '0;
			end else if (sel8 == SEL_VERSION) begin
				rd = VERSION_WORD;
			end else if (sel_entry) begin
				rd = sel8[0] ? ent_hi[win_pin] : ent_lo[win_pin];
			end
		end
	end

	// request decode
	always_comb begin
		go_scan    = 1'b0;
		go_read    = 1'b0;
		start_kind = OP_PIN;
		tgt_pin    = pin_index[PIN_W-1:0];
		case (s_tuser)
			CMD_READ: go_read = 1'b1;
			CMD_WRITE: begin
				if (offset == OFF_WINDOW && sel_entry) begin
					go_scan    = 1'b1;
					start_kind = sel8[0] ? OP_WR_HI : OP_WR_LO;
					tgt_pin    = win_pin;
				end else if (offset == OFF_EOI) begin
					go_scan    = 1'b1;
					start_kind = OP_EOI;
				end
			end
			CMD_PIN: go_scan = ({1'b0, pin_index} < 7'(NUM_PINS));
			default: go_scan = 1'b0;
		endcase
	end

	assign start     = accept && go_scan;
	assign en        = (state_q == ST_SCAN) && (!hold_v_q || out_free);
	assign scan_done = en && (op_q.kind != OP_EOI || tok_last);

	always_comb begin
		cop    = op_q;
		cop.en = en;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = go_scan ? ST_SCAN : ST_FLUSH;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_n = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q || out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= '0;
			hold_v_q    <= 1'b0;
			hold_kind_q <= 1'b0;
			hold_q      <= '0;
			out_v_q     <= 1'b0;
			out_kind_q  <= 1'b0;
			out_last_q  <= 1'b0;
			out_q       <= '0;
			op_q        <= '0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				op_q.kind    <= start_kind;
				op_q.wdata   <= wdata;
				op_q.level   <= s_tdata[46];
				op_q.accepts <= s_tdata[47];
				if (s_tuser == CMD_WRITE && offset == OFF_SELECT) begin
					sel_q <= wdata;
				end
				if (go_read) begin
					hold_v_q    <= 1'b1;
					hold_kind_q <= 1'b0;
					hold_q      <= {27'd0, rd};
				end
			end
			if (en && dlv.valid) begin
				if (hold_v_q) begin
					out_q      <= hold_q;
					out_kind_q <= hold_kind_q;
					out_last_q <= 1'b0;
				end
				hold_v_q    <= 1'b1;
				hold_kind_q <= 1'b1;
				hold_q      <= {dlv.mode, dlv.dest, dlv.vector, 32'd0};
			end
			if (state_q == ST_FLUSH && hold_v_q && out_free) begin
				out_q      <= hold_q;
				out_kind_q <= hold_kind_q;
				out_last_q <= 1'b1;
				hold_v_q   <= 1'b0;
			end
			if ((en && dlv.valid && hold_v_q)
					|| (state_q == ST_FLUSH && hold_v_q && out_free)) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	iirc_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.tgt_pin    (tgt_pin),
		.start_kind (start_kind),
		.op         (cop),
		.ent_lo     (ent_lo),
		.ent_hi     (ent_hi),
		.tok_last   (tok_last),
		.dlv        (dlv)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: design/iirc_cell.sv
// ----------------------------------------------------------------------------
// iirc_cell
// One pin: redirection entry, pending request and pin level; acts on token.
// ----------------------------------------------------------------------------
module iirc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              inject,
	input  logic              tok_in,
	input  iirc_pkg::cell_op_t op,
	output logic              tok_out,
	output logic [31:0]       ent_lo,
	output logic [31:0]       ent_hi,
	output iirc_pkg::dlv_t    dlv
);
	import iirc_pkg::*;

	logic        tok_q;
	logic [31:0] lo_q, hi_q;
	logic        pend_q, lvl_q;
	logic [31:0] lo_n, hi_n;
	logic        pend_n, lvl_n, svc, act, fire;

	assign act = tok_q && op.en;

	always_comb begin
		lo_n   = lo_q;
		hi_n   = hi_q;
		pend_n = pend_q;
		lvl_n  = lvl_q;
		svc    = 1'b0;
		case (op.kind)
			OP_WR_LO: begin
				lo_n = (op.wdata & ~RO_BITS) | (lo_q & RO_BITS);
				if (!lo_n[B_LEVEL]) begin
					lo_n[B_RIRR] = 1'b0;
				end
				svc = 1'b1;
			end
			OP_WR_HI: begin
				hi_n = op.wdata;
				svc  = 1'b1;
			end
			OP_EOI: begin
				if (lo_q[B_LEVEL] && lo_q[B_RIRR] && lo_q[7:0] == op.wdata[7:0]) begin
					lo_n[B_RIRR] = 1'b0;
					svc          = 1'b1;
				end
			end
			OP_PIN: begin
				lvl_n = op.level;
				if (lo_q[B_LEVEL]) begin
					pend_n = op.level;
					svc    = op.level;
				end else if (op.level && !lvl_q && !lo_q[B_MASK]) begin
					pend_n = 1'b1;
					svc    = 1'b1;
				end
			end
			default: svc = 1'b0;
		endcase
		fire = act && svc && pend_n && !lo_n[B_MASK] && !(lo_n[B_LEVEL] && lo_n[B_RIRR])
			&& op.accepts;
		dlv.valid  = fire;
		dlv.vector = fire ? lo_n[7:0] : 8'd0;
		dlv.dest   = fire ? hi_n[31:16] : 16'd0;
		dlv.mode   = fire ? lo_n[10:8] : 3'd0;
		if (fire) begin
			if (lo_n[B_LEVEL]) begin
				lo_n[B_RIRR] = 1'b1;
			end else begin
				pend_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			lo_q   <= 32'd1 << B_MASK;
			hi_q   <= '0;
			pend_q <= 1'b0;
			lvl_q  <= 1'b0;
		end else begin
			if (start) begin
				tok_q <= inject;
			end else if (op.en) begin
				tok_q <= tok_in && (op.kind == OP_EOI);
			end
			if (act) begin
				lo_q   <= lo_n;
				hi_q   <= hi_n;
				pend_q <= pend_n;
				lvl_q  <= lvl_n;
			end
		end
	end

	assign tok_out = tok_q;
	assign ent_lo  = lo_q;
	assign ent_hi  = hi_q;

endmodule

FILE: design/iirc_chain.sv
// ----------------------------------------------------------------------------
// iirc_chain
// Row of pin cells; an EOI token walks from pin to pin, one cell per step.
// ----------------------------------------------------------------------------
module iirc_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [iirc_pkg::PIN_W-1:0] tgt_pin,
	input  iirc_pkg::op_e_t            start_kind,
	input  iirc_pkg::cell_op_t         op,
	output logic [31:0]                ent_lo [iirc_pkg::NUM_PINS],
	output logic [31:0]                ent_hi [iirc_pkg::NUM_PINS],
	output logic                       tok_last,
	output iirc_pkg::dlv_t             dlv
);
	import iirc_pkg::*;

	logic [NUM_PINS-1:0] tok;
	logic [NUM_PINS-1:0] inject;
	logic [NUM_PINS-1:0] fire;
	dlv_t                cdlv [NUM_PINS];

	always_comb begin
		for (int i = 0; i < NUM_PINS; i++) begin
			inject[i] = (start_kind == OP_EOI) ? (i == 0) : (tgt_pin == PIN_W'(i));
		end
	end

	for (genvar g = 0; g < NUM_PINS; g++) begin : g_cell
		iirc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (start),
			.inject  (inject[g]),
			.tok_in  ((g == 0) ? 1'b0 : tok[(g == 0) ? 0 : g - 1]),
			.op      (op),
			.tok_out (tok[g]),
			.ent_lo  (ent_lo[g]),
			.ent_hi  (ent_hi[g]),
			.dlv     (cdlv[g])
		);
		assign fire[g] = cdlv[g].valid;
	end

	always_comb begin
		dlv = '0;
		for (int i = 0; i < NUM_PINS; i++) begin
			dlv = dlv | cdlv[i];
		end
	end

	assign tok_last = tok[NUM_PINS-1];

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok))
		else $error("more than one cell holds the token");
	a_fire_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(fire))
		else $error("several cells deliver in one step");
	a_fire_en: assert property (@(posedge clk) disable iff (!arst_n) !op.en |-> fire == '0)
		else $error("delivery without a step");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I/O interrupt redirection controller: drives
// bus reads, writes, EOIs and pin events over the request stream, predicts
// reads and deliveries in a local copy of the redirection state, and checks
// every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import iirc_pkg::*;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  offset;
		logic [31:0] wdata;
		logic [5:0]  pin;
		logic        level;
		logic        accepts;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] rdata;
		logic [7:0]  vector;
		logic [15:0] dest;
		logic [2:0]  mode;
		logic        last;
	} irq_result_t;

	localparam logic [31:0] E_MASK  = 32'd1 << B_MASK;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	logic [63:0] entries [NUM_PINS];
	logic [NUM_PINS-1:0] pending;
	logic [NUM_PINS-1:0] levels;
	logic [31:0] sel_reg;

	request_t    pending_reqs [$];
	irq_result_t expected_results [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          deliveries_seen = 0;
	int          reqs_sent = 0;
	bit          calm = 1'b0;

	io_interrupt_redirection_controller_core dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string what);
		mismatches++;
		$display("error %0t: %s", $realtime, what);
	endtask

	task automatic push_result(input logic kind, input logic [31:0] rd, input logic [7:0] v,
			input logic [15:0] d, input logic [2:0] m);
		irq_result_t r;
		r = '{kind, rd, v, d, m, 1'b0};
		expected_results.push_back(r);
	endtask

	task automatic service_pin(input int p, input logic acc);
		logic [31:0] lo;
		lo = entries[p][31:0];
		if (!pending[p] || lo[B_MASK]) return;
		if (lo[B_LEVEL] && lo[B_RIRR]) return;
		if (!acc) return;
		push_result(1'b1, 32'd0, lo[7:0], entries[p][63:48], lo[10:8]);
		if (lo[B_LEVEL]) entries[p][B_RIRR] = 1'b1;
		else pending[p] = 1'b0;
	endtask

	task automatic predict_request(input request_t q);
		int n0, p;
		logic [7:0] s;
		logic [31:0] v, nl;
		n0 = expected_results.size();
		s = sel_reg[7:0];
		p = (int'(s) - int'(SEL_ENTRY_BASE)) >> 1;
		case (q.cmd)
			CMD_READ: begin
				v = '0;
				if (q.offset == OFF_SELECT) v = sel_reg;
				else if (q.offset == OFF_WINDOW) begin
					if (s == SEL_VERSION) v = VERSION_WORD;
					else if (s >= SEL_ENTRY_BASE && s <= SEL_ENTRY_LAST)
						v = s[0] ? entries[p][63:32] : entries[p][31:0];
				end
				push_result(1'b0, v, 8'd0, 16'd0, 3'd0);
			end
			CMD_WRITE: begin
				if (q.offset == OFF_SELECT) sel_reg = q.wdata;
				else if (q.offset == OFF_WINDOW) begin
					if (s >= SEL_ENTRY_BASE && s <= SEL_ENTRY_LAST) begin
						if (s[0]) entries[p][63:32] = q.wdata;
						else begin
							nl = (q.wdata & ~RO_BITS) | (entries[p][31:0] & RO_BITS);
							if (!nl[B_LEVEL]) nl[B_RIRR] = 1'b0;
							entries[p][31:0] = nl;
						end
						service_pin(p, q.accepts);
					end
				end else if (q.offset == OFF_EOI) begin
					for (int i = 0; i < NUM_PINS; i++) begin
						if (entries[i][B_LEVEL] && entries[i][B_RIRR]
								&& entries[i][7:0] == q.wdata[7:0]) begin
							entries[i][B_RIRR] = 1'b0;
							service_pin(i, q.accepts);
						end
					end
				end
			end
			CMD_PIN: begin
				if (q.pin < NUM_PINS) begin
					logic was;
					p = q.pin;
					was = levels[p];
					levels[p] = q.level;
					if (entries[p][B_LEVEL]) begin
						pending[p] = q.level;
						if (q.level) service_pin(p, q.accepts);
					end else if (q.level && !was && !entries[p][B_MASK]) begin
						pending[p] = 1'b1;
						service_pin(p, q.accepts);
					end
				end
			end
			default: ;
		endcase
		if (expected_results.size() > n0)
			expected_results[expected_results.size()-1].last = 1'b1;
	endtask

	task automatic queue_req(input logic [1:0] c, input logic [7:0] o, input logic [31:0] d,
			input logic [5:0] p, input logic l, input logic a);
		request_t q;
		q = '{c, o, d, p, l, a};
		pending_reqs.push_back(q);
	endtask

	// accept-side driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_request(request_t'({s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[45:40],
				s_tdata[46], s_tdata[47]}));
			reqs_sent++;
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
				request_t q;
				q = pending_reqs.pop_front();
				s_tuser <= q.cmd;
				s_tdata <= {q.accepts, q.level, q.pin, q.wdata, q.offset};
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			irq_result_t got, exp;
			got = '{m_tuser[0], m_tdata[31:0], m_tdata[39:32], m_tdata[55:40],
				m_tdata[58:56], m_tlast};
			results_seen++;
			if (got.kind) deliveries_seen++;
			if (expected_results.size() == 0)
				report($sformatf("unexpected result %h", got));
			else begin
				exp = expected_results.pop_front();
				if (got.kind != exp.kind) report($sformatf("kind %0d exp %0d", got.kind, exp.kind));
				if (got.rdata != exp.rdata) report($sformatf("read_data %h exp %h", got.rdata, exp.rdata));
				if (got.vector != exp.vector) report($sformatf("vector %h exp %h", got.vector, exp.vector));
				if (got.dest != exp.dest) report($sformatf("destination %h exp %h", got.dest, exp.dest));
				if (got.mode != exp.mode) report($sformatf("mode %0d exp %0d", got.mode, exp.mode));
				if (got.last != exp.last) report($sformatf("last %0d exp %0d", got.last, exp.last));
			end
		end
		if (arst_n) m_tready <= calm || $urandom_range(99) >= 18;
	end

	task automatic sel_write(input logic [31:0] d);
		queue_req(CMD_WRITE, OFF_SELECT, d, 6'd0, 1'b0, 1'b1);
	endtask

	task automatic win_write(input logic [31:0] d, input logic a);
		queue_req(CMD_WRITE, OFF_WINDOW, d, 6'd0, 1'b0, a);
	endtask

	task automatic win_read();
		queue_req(CMD_READ, OFF_WINDOW, $urandom, 6'd0, 1'b0, 1'b1);
	endtask

	task automatic random_program(input int p);
		logic [31:0] lo;
		lo = $urandom & ~E_MASK;
		if ($urandom_range(3) == 0) lo = lo | E_MASK;
		lo[7:0] = 8'($urandom_range(7)) ^ 8'(($urandom_range(1)) ? 8'hf8 : 8'h00);
		sel_write(32'(SEL_ENTRY_BASE) + 2 * p + 1);
		win_write($urandom, 1'b1);
		sel_write(32'(SEL_ENTRY_BASE) + 2 * p);
		win_write(lo, $urandom_range(3) != 0);
	endtask

	initial begin
		int p, k;
		for (int i = 0; i < NUM_PINS; i++) entries[i] = 64'(E_MASK);
		pending = '0;
		levels = '0;
		sel_reg = '0;

		// directed: register reads, extremes, level/edge programming, EOI fan-out
		queue_req(CMD_READ, OFF_SELECT, 32'd0, 6'd0, 1'b0, 1'b0);
		win_read();
		sel_write(32'(SEL_VERSION));
		win_read();
		sel_write(32'hffffffff);
		queue_req(CMD_READ, OFF_SELECT, 32'd0, 6'd0, 1'b0, 1'b0);
		win_read();
		win_write(32'hffffffff, 1'b1);
		queue_req(CMD_READ, OFF_EOI, 32'd0, 6'd0, 1'b0, 1'b0);
		queue_req(CMD_READ, 8'hff, 32'd0, 6'h3f, 1'b1, 1'b1);
		queue_req(CMD_WRITE, 8'hff, 32'hffffffff, 6'h3f, 1'b1, 1'b1);
		queue_req(2'd3, 8'h10, 32'hffffffff, 6'h3f, 1'b1, 1'b1);
		queue_req(CMD_PIN, 8'h00, 32'd0, 6'h3f, 1'b1, 1'b1);
		for (int i = 0; i < 3; i++) begin
			sel_write(32'(SEL_ENTRY_BASE) + 2 * i + 1);
			win_write(32'hffff0000, 1'b1);
			sel_write(32'(SEL_ENTRY_BASE) + 2 * i);
			win_write(32'h0000_f7a5 | RO_BITS, 1'b1);
		end
		for (int i = 0; i < 3; i++) queue_req(CMD_PIN, 8'd0, 32'd0, 6'(i), 1'b1, 1'b1);
		win_read();
		queue_req(CMD_WRITE, OFF_EOI, 32'hffffffa5, 6'd0, 1'b0, 1'b1);
		queue_req(CMD_WRITE, OFF_EOI, 32'h000000a5, 6'd0, 1'b0, 1'b0);
		queue_req(CMD_WRITE, OFF_EOI, 32'h000000a5, 6'd0, 1'b0, 1'b1);
		sel_write(32'(SEL_ENTRY_BASE) + 2 * (NUM_PINS - 1));
		win_write(32'h0000_0000, 1'b0);
		queue_req(CMD_PIN, 8'd0, 32'd0, 6'(NUM_PINS - 1), 1'b1, 1'b0);
		win_write(32'h0000_0042, 1'b1);
		win_read();

		// random: mostly program, toggle, read, EOI
		for (int n = 0; n < 400; ) begin
			k = $urandom_range(99);
			p = (k < 3) ? $urandom_range(63) : $urandom_range(NUM_PINS - 1);
			if (k < 15) begin
				random_program(p);
				n += 4;
			end else if (k < 55) begin
				queue_req(CMD_PIN, 8'($urandom), $urandom, 6'(p), 1'($urandom),
					$urandom_range(5) != 0);
				n++;
			end else if (k < 70) begin
				queue_req(CMD_WRITE, OFF_EOI, ($urandom & 32'hffffff00) | 32'($urandom_range(7)),
					6'($urandom), 1'($urandom), $urandom_range(5) != 0);
				n++;
			end else if (k < 82) begin
				sel_write(32'($urandom_range(SEL_ENTRY_LAST + 2)) | ($urandom & 32'hffffff00));
				win_read();
				n += 2;
			end else if (k < 88) begin
				queue_req(CMD_READ, 8'($urandom), $urandom, 6'($urandom), 1'($urandom),
					1'($urandom));
				n++;
			end else if (k < 94) begin
				queue_req(2'($urandom), 8'($urandom), $urandom, 6'($urandom), 1'($urandom),
					1'($urandom));
				n++;
			end else begin
				win_write($urandom, 1'($urandom));
				n++;
			end
			if (n > 150 && n < 230) calm = 1'b1;
			else if (n >= 230) calm = 1'b0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		wait (expected_results.size() == 0);
		repeat (NUM_PINS + 40) @(posedge clk);
		$display("requests accepted: %0d, results checked: %0d (%0d deliveries)",
			reqs_sent, results_seen, deliveries_seen);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout, %0d results outstanding", expected_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
design/iirc_pkg.sv
design/iirc_cell.sv
design/iirc_chain.sv
design/io_interrupt_redirection_controller_core.sv
dv/testbench.sv
